FILE: hw/rtl/amad_pkg.sv
// Shared types and constants for the armed motion alarm detector.
package amad_pkg;

    localparam int SAMPLE_BITS      = 12;
    localparam int READS_PER_MEAS   = 8;
    localparam int CAL_MEASUREMENTS = 64;
    localparam int N_LANES          = 3;

    localparam int READ_IDX_W = (READS_PER_MEAS > 1) ? $clog2(READS_PER_MEAS) : 1;
    localparam int MEAS_IDX_W = (CAL_MEASUREMENTS > 1) ? $clog2(CAL_MEASUREMENTS) : 1;
    localparam int READ_SUM_W = SAMPLE_BITS + $clog2(READS_PER_MEAS);
    localparam int CAL_SUM_W  = SAMPLE_BITS + $clog2(CAL_MEASUREMENTS);

    localparam int THR_W      = 12;
    localparam int HITS_W     = 8;
    localparam int TICK_W     = 16;
    localparam int DEV_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [HITS_W-1:0] HITS_MAX = 8'd255;

    localparam logic [THR_W-1:0]  RST_THR_X       = 12'd150;
    localparam logic [THR_W-1:0]  RST_THR_Y       = 12'd150;
    localparam logic [THR_W-1:0]  RST_THR_Z       = 12'd200;
    localparam logic [HITS_W-1:0] RST_HITS_REQ    = 8'd8;
    localparam logic [TICK_W-1:0] RST_IGNORE      = 16'd300;
    localparam logic [TICK_W-1:0] RST_DEBOUNCE    = 16'd5;
    localparam logic [TICK_W-1:0] RST_BUZZ_PERIOD = 16'd15;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_CAL      = 2'd1,
        MODE_ARMED    = 2'd2,
        MODE_ALARM    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_BUTTON = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_X       = 3'd0,
        CFG_THR_Y       = 3'd1,
        CFG_THR_Z       = 3'd2,
        CFG_HITS_REQ    = 3'd3,
        CFG_IGNORE      = 3'd4,
        CFG_DEBOUNCE    = 3'd5,
        CFG_BUZZ_PERIOD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [N_LANES-1:0][THR_W-1:0] threshold;
        logic [HITS_W-1:0]             hits_required;
        logic [TICK_W-1:0]             ignore_ticks;
        logic [TICK_W-1:0]             debounce_gap;
        logic [TICK_W-1:0]             buzz_period_ticks;
    } t_cfg;

    typedef struct packed {
        logic sample_en;
        logic meas_done;
        logic cal_mode;
        logic cal_done;
        logic clear_reads;
        logic clear_cal;
    } t_lane_ctl;

    typedef struct packed {
        t_mode             mode;
        logic              buzz_active;
        logic [HITS_W-1:0] motion_hits;
    } t_result;

endpackage

FILE: hw/rtl/armed_motion_alarm_detector_core.sv
// Top level of the armed motion alarm detector: configuration, lanes and result queue.
// The input channel carries one transaction per tick, sample read or button event,
// and every accepted transaction yields exactly one result transaction holding the
// mode, the buzzer phase and the current motion hit count after that item.
// Three axis lanes accumulate reads, build the calibration baselines and compare
// deviations against the thresholds; the control stage merges their hit flags.
// Each item is processed in the cycle it is accepted, so the input takes one
// transaction per clock while a queue entry is free, and its result is registered.
// Results wait in a two-entry queue; o_in_ready stays high while the queue has a
// free entry, so a stalled receiver holds back the input only once both entries
// are full. Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_wdata with no wait state; writes to unused indexes are dropped.
// Synchronous reset returns the block to disarmed with all counters cleared, the
// configuration at its default values and the result queue empty.
module armed_motion_alarm_detector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_op,
    input  logic [11:0]                         i_x_read,
    input  logic [11:0]                         i_y_read,
    input  logic [11:0]                         i_z_read,
    input  logic                                i_button_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_mode,
    output logic                                o_buzz_active,
    output logic [7:0]                          o_motion_hits,
    input  logic                                i_cfg_we,
    input  logic [amad_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [amad_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import amad_pkg::*;

    t_cfg       r_cfg;
    t_result    r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic                                fire;
    logic                                pop;
    t_lane_ctl                           lane_ctl;
    t_result                             res;
    logic [N_LANES-1:0]                  hit;
    logic [N_LANES-1:0][SAMPLE_BITS-1:0] samples;

    assign o_in_ready  = r_count != 2'd2;
    assign fire        = i_in_valid && o_in_ready;
    assign o_out_valid = r_count != 2'd0;
    assign pop         = o_out_valid && i_out_ready;

    assign samples[0] = SAMPLE_BITS'(i_x_read);
    assign samples[1] = SAMPLE_BITS'(i_y_read);
    assign samples[2] = SAMPLE_BITS'(i_z_read);

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        amad_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_sample    (samples[g]),
            .i_threshold (r_cfg.threshold[g]),
            .o_hit       (hit[g])
        );
    end

    amad_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (t_op'(i_op)),
        .i_button_level (i_button_level),
        .i_hit          (hit),
        .i_cfg          (r_cfg),
        .o_lane_ctl     (lane_ctl),
        .o_res          (res)
    );

    assign o_mode        = r_queue[r_rd_ptr].mode;
    assign o_buzz_active = r_queue[r_rd_ptr].buzz_active;
    assign o_motion_hits = r_queue[r_rd_ptr].motion_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold[0]      <= RST_THR_X;
            r_cfg.threshold[1]      <= RST_THR_Y;
            r_cfg.threshold[2]      <= RST_THR_Z;
            r_cfg.hits_required     <= RST_HITS_REQ;
            r_cfg.ignore_ticks      <= RST_IGNORE;
            r_cfg.debounce_gap      <= RST_DEBOUNCE;
            r_cfg.buzz_period_ticks <= RST_BUZZ_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THR_X:       r_cfg.threshold[0]      <= i_cfg_wdata[THR_W-1:0];
                CFG_THR_Y:       r_cfg.threshold[1]      <= i_cfg_wdata[THR_W-1:0];
                CFG_THR_Z:       r_cfg.threshold[2]      <= i_cfg_wdata[THR_W-1:0];
                CFG_HITS_REQ:    r_cfg.hits_required     <= i_cfg_wdata[HITS_W-1:0];
                CFG_IGNORE:      r_cfg.ignore_ticks      <= i_cfg_wdata[TICK_W-1:0];
                CFG_DEBOUNCE:    r_cfg.debounce_gap      <= i_cfg_wdata[TICK_W-1:0];
                CFG_BUZZ_PERIOD: r_cfg.buzz_period_ticks <= i_cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_queue[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (fire) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({fire, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/amad_lane.sv
// One axis lane: read averaging, calibration baseline and deviation check.
module amad_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  amad_pkg::t_lane_ctl                i_ctl,
    input  logic [amad_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic [amad_pkg::THR_W-1:0]         i_threshold,
    output logic                               o_hit
);
    import amad_pkg::*;

    logic [READ_SUM_W-1:0]  r_read_sum;
    logic [CAL_SUM_W-1:0]   r_cal_sum;
    logic [SAMPLE_BITS-1:0] r_base;

    logic [READ_SUM_W-1:0]  read_sum_new;
    logic [SAMPLE_BITS-1:0] meas;
    logic [CAL_SUM_W-1:0]   cal_sum_new;
    logic [SAMPLE_BITS-1:0] base_new;
    logic [SAMPLE_BITS-1:0] dev;

    assign read_sum_new = r_read_sum + READ_SUM_W'(i_sample);
    assign meas         = SAMPLE_BITS'(read_sum_new / READS_PER_MEAS);
    assign cal_sum_new  = r_cal_sum + CAL_SUM_W'(meas);
    assign base_new     = SAMPLE_BITS'(cal_sum_new / CAL_MEASUREMENTS);
    assign dev          = (meas >= r_base) ? (meas - r_base) : (r_base - meas);
    assign o_hit        = DEV_W'(dev) > DEV_W'(i_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_sum <= '0;
            r_cal_sum  <= '0;
            r_base     <= '0;
        end else begin
            if (i_ctl.clear_reads) begin
                r_read_sum <= '0;
            end else if (i_ctl.sample_en) begin
                r_read_sum <= i_ctl.meas_done ? '0 : read_sum_new;
            end
            if (i_ctl.clear_cal) begin
                r_cal_sum <= '0;
            end else if (i_ctl.sample_en && i_ctl.meas_done && i_ctl.cal_mode) begin
                r_cal_sum <= i_ctl.cal_done ? '0 : cal_sum_new;
            end
            if (i_ctl.sample_en && i_ctl.meas_done && i_ctl.cal_mode && i_ctl.cal_done) begin
                r_base <= base_new;
            end
        end
    end

endmodule

FILE: hw/rtl/amad_ctrl.sv
// Merging stage: mode, timing, button, hit counting and buzzer control.
module amad_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  amad_pkg::t_op                     i_op,
    input  logic                              i_button_level,
    input  logic [amad_pkg::N_LANES-1:0]      i_hit,
    input  amad_pkg::t_cfg                    i_cfg,
    output amad_pkg::t_lane_ctl               o_lane_ctl,
    output amad_pkg::t_result                 o_res
);
    import amad_pkg::*;

    t_mode                 r_mode, n_mode;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [TICK_W-1:0]     r_last_press, n_last_press;
    logic [TICK_W-1:0]     r_arm_done, n_arm_done;
    logic [TICK_W-1:0]     r_last_toggle, n_last_toggle;
    logic                  r_phase, n_phase;
    logic [HITS_W-1:0]     r_hits, n_hits;
    logic [READ_IDX_W-1:0] r_read_idx, n_read_idx;
    logic [MEAS_IDX_W-1:0] r_meas_idx, n_meas_idx;

    logic [TICK_W-1:0] arm_age;
    logic [TICK_W-1:0] press_age;
    logic [HITS_W-1:0] hits_sat;
    logic              sample_gate;
    logic              sample_en;
    logic              meas_done;
    logic              cal_done;
    logic              press_ok;
    logic              press_act;

    assign arm_age     = r_tick - r_arm_done;
    assign press_age   = r_tick - r_last_press;
    assign hits_sat    = (r_hits == HITS_MAX) ? HITS_MAX : r_hits + HITS_W'(1);
    assign sample_gate = (r_mode == MODE_CAL)
                      || ((r_mode == MODE_ARMED) && (arm_age > i_cfg.ignore_ticks));
    assign sample_en   = i_fire && (i_op == OP_SAMPLE) && sample_gate;
    assign meas_done   = r_read_idx == READ_IDX_W'(READS_PER_MEAS - 1);
    assign cal_done    = r_meas_idx == MEAS_IDX_W'(CAL_MEASUREMENTS - 1);
    assign press_ok    = i_fire && (i_op == OP_BUTTON) && (press_age >= i_cfg.debounce_gap);
    assign press_act   = press_ok && !i_button_level;

    assign o_lane_ctl.sample_en   = sample_en;
    assign o_lane_ctl.meas_done   = meas_done;
    assign o_lane_ctl.cal_mode    = r_mode == MODE_CAL;
    assign o_lane_ctl.cal_done    = cal_done;
    assign o_lane_ctl.clear_reads = press_act;
    assign o_lane_ctl.clear_cal   = press_act && (r_mode == MODE_DISARMED);

    assign o_res.mode        = n_mode;
    assign o_res.buzz_active = n_phase;
    assign o_res.motion_hits = n_hits;

    always_comb begin
        logic [TICK_W-1:0] toggle_age;
        n_mode        = r_mode;
        n_tick        = r_tick;
        n_last_press  = r_last_press;
        n_arm_done    = r_arm_done;
        n_last_toggle = r_last_toggle;
        n_phase       = r_phase;
        n_hits        = r_hits;
        n_read_idx    = r_read_idx;
        n_meas_idx    = r_meas_idx;
        toggle_age    = '0;
        if (i_fire) begin
            unique case (i_op)
                OP_TICK: begin
                    n_tick = r_tick + TICK_W'(1);
                end
                OP_SAMPLE: begin
                    if (sample_en) begin
                        n_read_idx = meas_done ? '0 : r_read_idx + READ_IDX_W'(1);
                        if (meas_done) begin
                            if (r_mode == MODE_CAL) begin
                                n_meas_idx = cal_done ? '0 : r_meas_idx + MEAS_IDX_W'(1);
                                if (cal_done) begin
                                    n_mode     = MODE_ARMED;
                                    n_arm_done = r_tick;
                                end
                            end else if (|i_hit) begin
                                if (hits_sat >= i_cfg.hits_required) begin
                                    n_hits = '0;
                                    n_mode = MODE_ALARM;
                                end else begin
                                    n_hits = hits_sat;
                                end
                            end else begin
                                n_hits = '0;
                            end
                        end
                    end
                end
                OP_BUTTON: begin
                    if (press_ok) begin
                        n_last_press = r_tick;
                        if (press_act) begin
                            n_read_idx = '0;
                            if (r_mode == MODE_DISARMED) begin
                                n_mode     = MODE_CAL;
                                n_meas_idx = '0;
                            end else begin
                                n_mode = MODE_DISARMED;
                            end
                        end
                    end
                end
                OP_NOP: begin
                end
            endcase
            toggle_age = n_tick - r_last_toggle;
            if (n_mode != MODE_ALARM) begin
                n_phase = 1'b0;
            end else if (toggle_age >= i_cfg.buzz_period_ticks) begin
                n_last_toggle = n_tick;
                n_phase       = !r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_DISARMED;
            r_tick        <= '0;
            r_last_press  <= '0;
            r_arm_done    <= '0;
            r_last_toggle <= '0;
            r_phase       <= 1'b0;
            r_hits        <= '0;
            r_read_idx    <= '0;
            r_meas_idx    <= '0;
        end else begin
            r_mode        <= n_mode;
            r_tick        <= n_tick;
            r_last_press  <= n_last_press;
            r_arm_done    <= n_arm_done;
            r_last_toggle <= n_last_toggle;
            r_phase       <= n_phase;
            r_hits        <= n_hits;
            r_read_idx    <= n_read_idx;
            r_meas_idx    <= n_meas_idx;
        end
    end

endmodule

FILE: tb/amad_status_checker.sv
// Checker that predicts and compares the status reported for every transaction of the detector.
module amad_status_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [11:0]                     i_x_read,
    input  logic [11:0]                     i_y_read,
    input  logic [11:0]                     i_z_read,
    input  logic                            i_button_level,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      i_mode,
    input  logic                            i_buzz_active,
    input  logic [7:0]                      i_motion_hits,
    input  logic                            i_cfg_we,
    input  logic [amad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [amad_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import amad_pkg::*;

    logic [N_LANES-1:0][THR_W-1:0]       thr;
    logic [HITS_W-1:0]                   hits_req;
    logic [TICK_W-1:0]                   ign_ticks;
    logic [TICK_W-1:0]                   deb_ticks;
    logic [TICK_W-1:0]                   buzz_ticks;

    t_mode                               mode_q;
    logic [TICK_W-1:0]                   tick_q;
    logic [TICK_W-1:0]                   press_tick_q;
    logic [TICK_W-1:0]                   armed_tick_q;
    logic [TICK_W-1:0]                   toggle_tick_q;
    logic                                buzz_q;
    logic [HITS_W-1:0]                   hits_q;
    int                                  reads_n;
    logic [N_LANES-1:0][READ_SUM_W-1:0]  read_acc;
    int                                  meas_n;
    logic [N_LANES-1:0][CAL_SUM_W-1:0]   cal_acc;
    logic [N_LANES-1:0][SAMPLE_BITS-1:0] base_q;

    t_result status_q[$];
    int      fail_n = 0;

    function automatic void clear_reads();
        reads_n  = 0;
        read_acc = '0;
    endfunction

    function automatic void fold_measurement(input logic [N_LANES-1:0][SAMPLE_BITS-1:0] meas);
        logic [SAMPLE_BITS-1:0] dev;
        logic                   hit;
        int                     a;
        hit = 1'b0;
        if (mode_q == MODE_CAL) begin
            for (a = 0; a < N_LANES; a++) begin
                cal_acc[a] += meas[a];
            end
            meas_n++;
            if (meas_n >= CAL_MEASUREMENTS) begin
                for (a = 0; a < N_LANES; a++) begin
                    base_q[a] = SAMPLE_BITS'(cal_acc[a] / CAL_MEASUREMENTS);
                end
                cal_acc      = '0;
                meas_n       = 0;
                mode_q       = MODE_ARMED;
                armed_tick_q = tick_q;
            end
            return;
        end
        for (a = 0; a < N_LANES; a++) begin
            dev = (meas[a] >= base_q[a]) ? meas[a] - base_q[a] : base_q[a] - meas[a];
            if (dev > thr[a]) begin
                hit = 1'b1;
            end
        end
        if (hit) begin
            if (hits_q != HITS_MAX) begin
                hits_q = hits_q + 1'b1;
            end
            if (hits_q >= hits_req) begin
                hits_q = '0;
                mode_q = MODE_ALARM;
            end
        end else begin
            hits_q = '0;
        end
    endfunction

    function automatic void take_sample(input logic [N_LANES-1:0][SAMPLE_BITS-1:0] rd);
        logic [TICK_W-1:0]                   elapsed;
        logic [N_LANES-1:0][SAMPLE_BITS-1:0] meas;
        int                                  a;
        elapsed = tick_q - armed_tick_q;
        if (mode_q == MODE_ARMED) begin
            if (elapsed <= ign_ticks) begin
                return;
            end
        end else if (mode_q != MODE_CAL) begin
            return;
        end
        for (a = 0; a < N_LANES; a++) begin
            read_acc[a] += rd[a];
        end
        reads_n++;
        if (reads_n < READS_PER_MEAS) begin
            return;
        end
        for (a = 0; a < N_LANES; a++) begin
            meas[a] = SAMPLE_BITS'(read_acc[a] / READS_PER_MEAS);
        end
        clear_reads();
        fold_measurement(meas);
    endfunction

    function automatic void press_event(input logic level);
        logic [TICK_W-1:0] since_press;
        since_press = tick_q - press_tick_q;
        if (since_press < deb_ticks) begin
            return;
        end
        press_tick_q = tick_q;
        if (level) begin
            return;
        end
        clear_reads();
        if (mode_q == MODE_DISARMED) begin
            mode_q  = MODE_CAL;
            meas_n  = 0;
            cal_acc = '0;
        end else begin
            mode_q = MODE_DISARMED;
        end
    endfunction

    function automatic t_result status_after(input t_op op,
                                             input logic [N_LANES-1:0][SAMPLE_BITS-1:0] rd,
                                             input logic level);
        t_result           r;
        logic [TICK_W-1:0] since_toggle;
        case (op)
            OP_TICK:   tick_q = tick_q + 1'b1;
            OP_SAMPLE: take_sample(rd);
            OP_BUTTON: press_event(level);
            default: ;
        endcase
        since_toggle = tick_q - toggle_tick_q;
        if (mode_q != MODE_ALARM) begin
            buzz_q = 1'b0;
        end else if (since_toggle >= buzz_ticks) begin
            toggle_tick_q = tick_q;
            buzz_q        = ~buzz_q;
        end
        r.mode        = mode_q;
        r.buzz_active = buzz_q;
        r.motion_hits = hits_q;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            thr           = {RST_THR_Z, RST_THR_Y, RST_THR_X};
            hits_req      = RST_HITS_REQ;
            ign_ticks     = RST_IGNORE;
            deb_ticks     = RST_DEBOUNCE;
            buzz_ticks    = RST_BUZZ_PERIOD;
            mode_q        = MODE_DISARMED;
            tick_q        = '0;
            press_tick_q  = '0;
            armed_tick_q  = '0;
            toggle_tick_q = '0;
            buzz_q        = 1'b0;
            hits_q        = '0;
            meas_n        = 0;
            cal_acc       = '0;
            base_q        = '0;
            clear_reads();
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THR_X:       thr[0]     = i_cfg_wdata[THR_W-1:0];
                    CFG_THR_Y:       thr[1]     = i_cfg_wdata[THR_W-1:0];
                    CFG_THR_Z:       thr[2]     = i_cfg_wdata[THR_W-1:0];
                    CFG_HITS_REQ:    hits_req   = i_cfg_wdata[HITS_W-1:0];
                    CFG_IGNORE:      ign_ticks  = i_cfg_wdata;
                    CFG_DEBOUNCE:    deb_ticks  = i_cfg_wdata;
                    CFG_BUZZ_PERIOD: buzz_ticks = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    fail_n++;
                    $display("%0t: result transaction with nothing outstanding, mode %0d hits %0d",
                             $time, i_mode, i_motion_hits);
                end else begin
                    want = status_q.pop_front();
                    if (i_mode !== want.mode) begin
                        fail_n++;
                        $display("%0t: mode mismatch, expected %0d, actual %0d",
                                 $time, want.mode, i_mode);
                    end
                    if (i_buzz_active !== want.buzz_active) begin
                        fail_n++;
                        $display("%0t: buzzer mismatch, expected %0d, actual %0d",
                                 $time, want.buzz_active, i_buzz_active);
                    end
                    if (i_motion_hits !== want.motion_hits) begin
                        fail_n++;
                        $display("%0t: motion hits mismatch, expected %0d, actual %0d",
                                 $time, want.motion_hits, i_motion_hits);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                status_q.push_back(status_after(t_op'(i_op), {i_z_read, i_y_read, i_x_read},
                                                i_button_level));
            end
        end
        o_pending    <= status_q.size();
        o_fail_count <= fail_n;
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the armed motion alarm detector: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import amad_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_op;
    logic [11:0]           i_x_read;
    logic [11:0]           i_y_read;
    logic [11:0]           i_z_read;
    logic                  i_button_level;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_mode;
    logic                  o_buzz_active;
    logic [7:0]            o_motion_hits;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int items_sent = 0;
    int item_stop  = 0;
    int tx_pct     = 0;
    int rx_pct     = 0;
    int stall_left = 0;
    int cycles     = 0;
    int cur_thr[3];
    int cur_ign;
    int cur_deb;

    armed_motion_alarm_detector_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_x_read       (i_x_read),
        .i_y_read       (i_y_read),
        .i_z_read       (i_z_read),
        .i_button_level (i_button_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mode         (o_mode),
        .o_buzz_active  (o_buzz_active),
        .o_motion_hits  (o_motion_hits),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    amad_status_checker status_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_x_read       (i_x_read),
        .i_y_read       (i_y_read),
        .i_z_read       (i_z_read),
        .i_button_level (i_button_level),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_mode         (o_mode),
        .i_buzz_active  (o_buzz_active),
        .i_motion_hits  (o_motion_hits),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
            stall_left  <= $urandom_range(1, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [11:0] clip12(input int v);
        if (v < 0) begin
            return 12'd0;
        end
        if (v > 4095) begin
            return 12'd4095;
        end
        return v[11:0];
    endfunction

    function automatic int settle(input int ticks);
        return (ticks < 40) ? ticks + 1 : 40;
    endfunction

    task automatic send_item(input t_op op, input int x, input int y, input int z,
                             input logic level);
        if (items_sent >= item_stop) begin
            return;
        end
        if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_x_read       <= clip12(x);
        i_y_read       <= clip12(y);
        i_z_read       <= clip12(z);
        i_button_level <= level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_button(input logic level);
        send_item(OP_BUTTON, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), level);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic load_cfg(input int tx, input int ty, input int tz, input int hr,
                            input int ign, input int deb, input int buzz);
        cur_thr[0] = tx;
        cur_thr[1] = ty;
        cur_thr[2] = tz;
        cur_ign    = ign;
        cur_deb    = deb;
        write_reg(CFG_THR_X, tx);
        write_reg(CFG_THR_Y, ty);
        write_reg(CFG_THR_Z, tz);
        write_reg(CFG_HITS_REQ, hr);
        write_reg(CFG_IGNORE, ign);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_BUZZ_PERIOD, buzz);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic arm_and_watch(input int groups);
        int  base[3];
        int  rd[3];
        int  g, k, a, ax, noise, delta, run_left;
        bit  moving, upward;
        run_left = 0;
        moving   = 1'b0;
        repeat (settle(cur_deb)) send_tick();
        send_button(1'b0);
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(0, 3)) send_tick();
            send_button(1'b1);
        end
        for (a = 0; a < 3; a++) begin
            base[a] = $urandom_range(100, 3995);
        end
        for (g = 0; g < CAL_MEASUREMENTS * READS_PER_MEAS; g++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_tick();
            end
            if ($urandom_range(0, 299) == 0) begin
                send_item(OP_NOP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
            end
            for (a = 0; a < 3; a++) begin
                noise = $urandom_range(0, 8);
                rd[a] = base[a] + noise - 4;
            end
            send_item(OP_SAMPLE, rd[0], rd[1], rd[2], 1'($urandom_range(0, 1)));
        end
        drain();
        repeat (settle(cur_ign) + $urandom_range(0, 3)) send_tick();
        for (g = 0; g < groups; g++) begin
            if (run_left == 0) begin
                moving   = ($urandom_range(0, 99) < 55);
                run_left = $urandom_range(1, 6);
            end
            run_left--;
            ax     = $urandom_range(0, 2);
            delta  = $urandom_range(1, 300);
            delta  = delta + cur_thr[ax];
            upward = 1'($urandom_range(0, 1));
            for (k = 0; k < READS_PER_MEAS; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_tick();
                end
                for (a = 0; a < 3; a++) begin
                    noise = $urandom_range(0, 2);
                    rd[a] = base[a] + noise - 1;
                end
                if (moving) begin
                    rd[ax] = upward ? base[ax] + delta : base[ax] - delta;
                end
                send_item(OP_SAMPLE, rd[0], rd[1], rd[2], 1'($urandom_range(0, 1)));
            end
        end
        repeat ($urandom_range(0, 30)) send_tick();
        repeat (settle(cur_deb)) send_tick();
        send_button(1'b0);
    endtask

    task automatic scramble(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_tick();
            end else if (r < 65) begin
                send_item(OP_SAMPLE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                send_button(1'($urandom_range(0, 1)));
            end else begin
                send_item(OP_NOP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= OP_NOP;
        i_x_read       <= '0;
        i_y_read       <= '0;
        i_z_read       <= '0;
        i_button_level <= 1'b1;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_THR_X;
        i_cfg_wdata    <= '0;
        cur_thr[0]     = RST_THR_X;
        cur_thr[1]     = RST_THR_Y;
        cur_thr[2]     = RST_THR_Z;
        cur_ign        = RST_IGNORE;
        cur_deb        = RST_DEBOUNCE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults after reset: debounce rejection, ignored samples, release and abort.
        tx_pct    = 10;
        rx_pct    = 4;
        item_stop = 100000;
        send_item(OP_NOP, 4095, 0, 4095, 1'b1);
        send_item(OP_SAMPLE, 4095, 4095, 4095, 1'b1);
        send_item(OP_SAMPLE, 0, 0, 0, 1'b0);
        send_button(1'b0);
        repeat (5) send_tick();
        send_button(1'b1);
        send_button(1'b0);
        repeat (5) send_tick();
        send_button(1'b0);
        send_item(OP_SAMPLE, 4095, 0, 4095, 1'b0);
        send_item(OP_SAMPLE, 0, 4095, 0, 1'b1);
        repeat (5) send_tick();
        send_button(1'b0);
        send_item(OP_NOP, 0, 4095, 0, 1'b0);

        drain();
        load_cfg(150, 150, 200, 4, 20, 3, 5);
        arm_and_watch($urandom_range(6, 16));

        drain();
        tx_pct = 0;
        rx_pct = 0;
        load_cfg(0, 0, 0, 1, 0, 0, 1);
        arm_and_watch($urandom_range(6, 16));

        drain();
        tx_pct = 25;
        rx_pct = 8;
        load_cfg(4095, 4095, 4095, 255, 65535, 65535, 65535);
        scramble(80);

        drain();
        tx_pct = 10;
        rx_pct = 4;
        load_cfg($urandom_range(20, 600), $urandom_range(20, 600), $urandom_range(20, 600),
                 $urandom_range(1, 6), $urandom_range(0, 40), $urandom_range(0, 8),
                 $urandom_range(1, 12));
        scramble(150);

        drain();
        tx_pct    = 0;
        rx_pct    = 0;
        item_stop = items_sent + 200;
        load_cfg($urandom_range(20, 600), $urandom_range(20, 600), $urandom_range(20, 600),
                 $urandom_range(1, 6), $urandom_range(0, 40), $urandom_range(0, 8),
                 $urandom_range(1, 12));
        arm_and_watch($urandom_range(6, 16));

        drain();
        $display("Sent %0d transactions over six register settings, extremes included.",
                 items_sent);
        $display("Covered debounce, calibration, ignore window, motion hits, alarm and buzzer.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/amad_pkg.sv
hw/rtl/amad_lane.sv
hw/rtl/amad_ctrl.sv
hw/rtl/armed_motion_alarm_detector_core.sv
tb/amad_status_checker.sv
tb/tb.sv
